// ===== sv/balt_pkg.sv =====
// Shared types and constants of the bounded adjacency-list table unit.
package balt_pkg;

    // Fixed field widths
    localparam int NODE_W     = 6;
    localparam int BITS_W     = 64;
    localparam int NCOUNT_W   = 7;
    localparam int DEGREE_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int SLOT_DW    = NODE_W + 1;   // valid flag over neighbor index

    // Operation codes
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREE = 1'd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] neighbor;
        logic [BITS_W-1:0] neighbor_bits;
    } t_item;

    typedef struct packed {
        logic [NODE_W-1:0] neighbor_out;
        logic              valid_res;
        logic              last;
        logic [1:0]        status;
    } t_result;

endpackage

// ===== sv/balt_item_if.sv =====
// Input item channel: valid/ready handshake with one table operation.
interface balt_item_if;
    import balt_pkg::*;

    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/balt_result_if.sv =====
// Result channel: valid/ready handshake with one result item.
interface balt_result_if;
    import balt_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/balt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module balt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bounded_adjacency_list_table_unit.sv =====
// Top level: graph adjacency table kept as fixed-stride neighbor slots in one RAM.
//
//  channel   | dir | handshake              | content
//  ----------+-----+------------------------+---------------------------------------
//  i_item    | in  | valid/ready            | op, node, neighbor, neighbor_bits
//  o_result  | out | valid/ready            | neighbor_out, valid_res, last, status
//  i_cfg_*   | in  | write enable, no wait  | 0 node_count, 1 max_degree
//
// One item at a time; ready is low from the input transfer, through S_DISPATCH, until idle:
// row load: S_SCAN, then S_CLEAR (one bitmap bit, then one cleared slot a cycle), S_RESP;
// add: S_ADD_RD, S_ADD_CHK per slot checked, S_RESP; a row never loaded: slot 0, then clear;
// read: S_RD_REQ, S_RD_CHK per slot, S_FLUSH if all usable slots full; range or empty: S_RESP.
// Reset clears one valid flag per row at once: a row never loaded reads as empty,
// so no clearing pass runs. A stalled result holds the response, the read walk and the flush.
module bounded_adjacency_list_table_unit #(
    parameter int MAX_NODES = 64,
    parameter int MAX_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    balt_item_if.sink                       i_item,
    balt_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [balt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [balt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import balt_pkg::*;

    localparam int DEPTH  = MAX_NODES * MAX_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_SCAN     = 10'b00_0000_0100,
        S_CLEAR    = 10'b00_0000_1000,
        S_ADD_RD   = 10'b00_0001_0000,
        S_ADD_CHK  = 10'b00_0010_0000,
        S_RD_REQ   = 10'b00_0100_0000,
        S_RD_CHK   = 10'b00_1000_0000,
        S_FLUSH    = 10'b01_0000_0000,
        S_RESP     = 10'b10_0000_0000
    } t_state;

    // Control registers
    t_state                r_state, n_state;
    logic                  r_o_valid, n_o_valid;
    logic [MAX_NODES-1:0]  r_row_valid, n_row_valid;
    logic [NCOUNT_W-1:0]   r_node_count;
    logic [DEGREE_W-1:0]   r_max_degree;

    // Working registers
    t_op                   r_op, n_op;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [NODE_W-1:0]     r_nb, n_nb;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic [NCOUNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_slot, n_slot;
    logic [NODE_W-1:0]     r_pend, n_pend;
    logic                  r_have_pend, n_have_pend;
    logic [1:0]            r_status, n_status;
    t_result               r_o_res, n_o_res;

    // RAM access
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [SLOT_DW-1:0]    mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [SLOT_DW-1:0]    mem_rdata;

    logic [NCOUNT_W-1:0]   nodes_eff;
    logic [CNT_W-1:0]      deg_eff;
    logic                  out_free;
    logic [ROW_W-1:0]      row;
    logic                  slot_used;

    balt_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Clamp the configuration to the built sizes
    assign nodes_eff = (r_node_count > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES)
                                                               : r_node_count;
    assign deg_eff   = ({2'b00, r_max_degree} > 7'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : CNT_W'(r_max_degree);

    assign out_free  = !r_o_valid || o_result.ready;
    assign row       = r_node[ROW_W-1:0];
    assign slot_used = mem_rdata[SLOT_DW-1];

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_o_valid;
    assign o_result.payload = r_o_res;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_o_valid   = r_o_valid && !o_result.ready;
        n_o_res     = r_o_res;
        n_row_valid = r_row_valid;
        n_op        = r_op;
        n_node      = r_node;
        n_nb        = r_nb;
        n_bits      = r_bits;
        n_base      = r_base;
        n_j         = r_j;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_base + ADDR_W'(r_fill);
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_base + ADDR_W'(r_slot);

        unique case (r_state)
            S_IDLE: begin
                // Capture the transfer
                if (i_item.valid) begin
                    n_op    = t_op'(i_item.payload.op);
                    n_node  = i_item.payload.node;
                    n_nb    = i_item.payload.neighbor;
                    n_bits  = i_item.payload.neighbor_bits;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_base      = ADDR_W'(row * MAX_SLOTS);
                n_status    = ST_OK;
                n_fill      = '0;
                n_slot      = '0;
                n_j         = '0;
                n_have_pend = 1'b0;
                if (r_op == OP_NONE) begin
                    n_state = S_IDLE;
                end else if ({1'b0, r_node} >= nodes_eff) begin
                    n_status = ST_RANGE;
                    n_state  = S_RESP;
                end else begin
                    unique case (r_op)
                        OP_LOAD: n_state = S_SCAN;
                        OP_ADD: begin
                            if (deg_eff == '0) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (!r_row_valid[row]) begin
                                // Fresh row: place the edge in slot 0, clear the rest
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(row * MAX_SLOTS);
                                mem_wdata = {1'b1, r_nb};
                                n_fill    = CNT_W'(1);
                                n_state   = S_CLEAR;
                            end else begin
                                n_state = S_ADD_RD;
                            end
                        end
                        OP_READ: begin
                            if (deg_eff == '0 || !r_row_valid[row]) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_RD_REQ;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                // One bitmap bit per cycle, kept neighbors packed in ascending order
                if (r_j == nodes_eff) begin
                    n_state = S_CLEAR;
                end else begin
                    if (r_bits[0]) begin
                        if (r_fill < deg_eff) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b1, r_j[NODE_W-1:0]};
                            n_fill    = r_fill + CNT_W'(1);
                        end else begin
                            n_status = ST_TRUNC;
                        end
                    end
                    n_bits = r_bits >> 1;
                    n_j    = r_j + NCOUNT_W'(1);
                end
            end

            S_CLEAR: begin
                // Free the tail of the row, then mark the row as written
                if (r_fill == CNT_W'(MAX_SLOTS)) begin
                    n_row_valid[row] = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    mem_we = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                end
            end

            S_ADD_RD: begin
                mem_re  = 1'b1;
                n_state = S_ADD_CHK;
            end

            S_ADD_CHK: begin
                // First free slot takes the edge; no free slot drops it
                if (!slot_used) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_base + ADDR_W'(r_slot);
                    mem_wdata = {1'b1, r_nb};
                    n_state   = S_RESP;
                end else if (r_slot + CNT_W'(1) == deg_eff) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_slot  = r_slot + CNT_W'(1);
                    n_state = S_ADD_RD;
                end
            end

            S_RD_REQ: begin
                mem_re  = 1'b1;
                n_state = S_RD_CHK;
            end

            S_RD_CHK: begin
                // Hold one neighbor back so the final one can carry last
                if (out_free) begin
                    if (!slot_used) begin
                        n_o_valid = 1'b1;
                        n_o_res   = r_have_pend ? '{r_pend, 1'b1, 1'b1, ST_OK}
                                                : '{'0, 1'b0, 1'b1, ST_OK};
                        n_state   = S_IDLE;
                    end else begin
                        if (r_have_pend) begin
                            n_o_valid = 1'b1;
                            n_o_res   = '{r_pend, 1'b1, 1'b0, ST_OK};
                        end
                        n_pend      = mem_rdata[NODE_W-1:0];
                        n_have_pend = 1'b1;
                        if (r_slot + CNT_W'(1) == deg_eff) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_slot  = r_slot + CNT_W'(1);
                            n_state = S_RD_REQ;
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_res   = '{r_pend, 1'b1, 1'b1, ST_OK};
                    n_state   = S_IDLE;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_res   = '{'0, 1'b0, 1'b1, r_status};
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_o_valid   <= n_o_valid;
            r_row_valid <= n_row_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NCOUNT_W'(64);
            r_max_degree <= DEGREE_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NODE_COUNT: r_node_count <= i_cfg_data[NCOUNT_W-1:0];
                REG_MAX_DEGREE: r_max_degree <= i_cfg_data[DEGREE_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_node      <= n_node;
        r_nb        <= n_nb;
        r_bits      <= n_bits;
        r_base      <= n_base;
        r_j         <= n_j;
        r_fill      <= n_fill;
        r_slot      <= n_slot;
        r_pend      <= n_pend;
        r_have_pend <= n_have_pend;
        r_status    <= n_status;
        r_o_res     <= n_o_res;
    end
endmodule
